FILE: sv/srcw_pkg.sv
// Shared types, constants and helpers for the slot-ROM configuration window.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
package srcw_pkg;

    // Field widths
    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int SLOT_W = 3;
    localparam int PTR_W  = 12;
    localparam int NIB_W  = 4;

    // Parameter defaults
    localparam int BUFFER_DEPTH_DEF = 4096;
    localparam int NUM_SLOTS_DEF    = 7;

    // Scratch area spans offsets F0..FF of each slot
    localparam int SCR_SPAN = 16;

    // Pointer reduction steps: smallest buffer holds 256 bytes,
    // so the quotient of a 12-bit pointer fits in PTR_W - 8 bits
    localparam int RED_STEPS = PTR_W - 8;

    // Window offsets
    localparam logic [DATA_W-1:0] OFF_EC = 8'hEC;
    localparam logic [DATA_W-1:0] OFF_ED = 8'hED;
    localparam logic [DATA_W-1:0] OFF_EE = 8'hEE;
    localparam logic [DATA_W-1:0] OFF_EF = 8'hEF;
    localparam logic [DATA_W-1:0] OFF_FB = 8'hFB;
    localparam logic [NIB_W-1:0]  SCR_HI = 4'hF;

    // Access kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Signature characters in the scratch area
    localparam logic [DATA_W-1:0] CH_FILL  = 8'hFF;
    localparam logic [DATA_W-1:0] CH_V     = 8'h56;
    localparam logic [DATA_W-1:0] CH_2     = 8'h32;
    localparam logic [DATA_W-1:0] CH_A     = 8'h41;
    localparam logic [DATA_W-1:0] CH_C     = 8'h43;
    localparam logic [DATA_W-1:0] CH_0     = 8'h30;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESP
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic finish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } status_t;

    // Reset content of a scratch byte; offset FB lives outside the scratch RAM
    function automatic logic [DATA_W-1:0] scr_init(input logic [SLOT_W-1:0] slot,
                                                    input logic [NIB_W-1:0] idx);
        logic [DATA_W-1:0] val;
        if (idx[NIB_W-1] == 1'b0) begin
            val = CH_FILL;
        end else begin
            unique case (idx[NIB_W-2:0])
                3'd0:    val = CH_V;
                3'd1:    val = CH_2;
                3'd2:    val = CH_A;
                3'd4:    val = CH_C;
                3'd5:    val = CH_0 + {{(DATA_W-SLOT_W){1'b0}}, slot};
                3'd6:    val = CH_0;
                3'd7:    val = CH_0;
                default: val = '0;
            endcase
        end
        return val;
    endfunction

endpackage

FILE: sv/slot_rom_config_window_top.sv
// Slot-ROM configuration window. An accepted item is registered in the item registers,
// and its result then enters the output register once that register is free. The block
// takes one item at a time: the input stays stalled until the result enters the output register.
// Reset: asynchronous, active low. After reset a clearing pass zeroes all BUFFER_DEPTH
// buffer entries (4096 by default), with the input stalled; card_type writes
// are taken throughout. Depends on srcw_pkg, srcw_ctrl and srcw_dp.
module slot_rom_config_window_top #(
    parameter int BUFFER_DEPTH = srcw_pkg::BUFFER_DEPTH_DEF,
    parameter int NUM_SLOTS    = srcw_pkg::NUM_SLOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        kind,
    input  logic [srcw_pkg::ADDR_W-1:0] address,
    input  logic [srcw_pkg::DATA_W-1:0] data,
    input  logic                        rom_select,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [srcw_pkg::DATA_W-1:0] read_data,
    output logic                        window_hit,
    input  logic                        cfg_wr_en,
    input  logic [srcw_pkg::DATA_W-1:0] cfg_wr_data
);
    import srcw_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer
    srcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // Storage and decode
    srcw_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .NUM_SLOTS    (NUM_SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .kind        (kind),
        .address     (address),
        .data        (data),
        .rom_select  (rom_select),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .read_data   (read_data),
        .window_hit  (window_hit)
    );

endmodule

FILE: sv/srcw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Used for the configuration buffer and the scratch bytes. No dependencies.
module srcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, hold when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/srcw_ctrl.sv
// Sequencer for the slot-ROM configuration window: clearing pass, accept, respond.
// Depends on srcw_pkg for the state, command and status types.
module srcw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  srcw_pkg::status_t status,
    output srcw_pkg::cmd_t    cmd,
    output logic              in_stall
);
    import srcw_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                cmd.finish = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

FILE: sv/srcw_dp.sv
// Datapath: address decode, pointer, per-slot window bytes, buffer and scratch RAMs,
// and the output register. Depends on srcw_pkg and srcw_ram.
module srcw_dp #(
    parameter int BUFFER_DEPTH = srcw_pkg::BUFFER_DEPTH_DEF,
    parameter int NUM_SLOTS    = srcw_pkg::NUM_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  srcw_pkg::cmd_t                cmd,
    output srcw_pkg::status_t             status,
    input  logic                          kind,
    input  logic [srcw_pkg::ADDR_W-1:0]   address,
    input  logic [srcw_pkg::DATA_W-1:0]   data,
    input  logic                          rom_select,
    input  logic                          cfg_wr_en,
    input  logic [srcw_pkg::DATA_W-1:0]   cfg_wr_data,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [srcw_pkg::DATA_W-1:0]   read_data,
    output logic                          window_hit
);
    import srcw_pkg::*;

    localparam int BUF_AW    = $clog2(BUFFER_DEPTH);
    localparam int SCR_DEPTH = (NUM_SLOTS + 1) * SCR_SPAN;
    localparam int SCR_AW    = $clog2(SCR_DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(NUM_SLOTS);
    localparam logic [BUF_AW-1:0] CLR_LAST = BUF_AW'(BUFFER_DEPTH - 1);

    // Per-slot window bytes
    logic [DATA_W-1:0] ec_reg [1:NUM_SLOTS];
    logic [NIB_W-1:0]  ed_reg [1:NUM_SLOTS];
    logic [DATA_W-1:0] ee_reg [1:NUM_SLOTS];
    logic [DATA_W-1:0] fb_reg [1:NUM_SLOTS];

    // Pointer and its buffer address
    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  ptr_next;
    logic [PTR_W-1:0]  ptr_mod;
    logic [BUF_AW-1:0] buf_addr_reg;
    logic [BUF_AW-1:0] buf_rd_addr;

    // Clearing sweep
    logic [BUF_AW-1:0] clr_cnt_reg;

    // Scratch valid bits
    logic [SCR_DEPTH-1:0] scr_vld_vec_reg;

    // Item held between accept and result
    logic [SLOT_W-1:0] slot_reg;
    logic [NIB_W-1:0]  off4_reg;
    logic              hit_reg;
    logic              refresh_reg;
    logic              use_scr_reg;
    logic              scr_vld_reg;
    logic [DATA_W-1:0] held_reg;
    logic              fwd_reg;
    logic [DATA_W-1:0] fwd_data_reg;

    // Output register
    logic              out_valid_reg;
    logic [DATA_W-1:0] read_data_reg;
    logic              window_hit_reg;

    // Decode
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] off;
    logic              hit;
    logic              rd_hit;
    logic              wr_ec;
    logic              wr_ed;
    logic              wr_ef;
    logic              rd_ee;
    logic              in_scr_area;
    logic              wr_fb;
    logic              wr_scr;
    logic              use_scr;
    logic              refresh;
    logic [DATA_W-1:0] rd_pre;
    logic [SCR_AW-1:0] scr_idx;

    // RAM ports
    logic              buf_wr_en;
    logic [BUF_AW-1:0] buf_wr_addr;
    logic [DATA_W-1:0] buf_wr_data;
    logic [DATA_W-1:0] buf_rd_data;
    logic [DATA_W-1:0] scr_rd_data;
    logic [DATA_W-1:0] refresh_byte;
    logic [DATA_W-1:0] result_byte;

    // Decode the access
    assign slot        = address[8 +: SLOT_W];
    assign off         = address[DATA_W-1:0];
    assign hit         = rom_select && (slot != '0) && (slot <= SLOT_MAX) && (off >= OFF_EC);
    assign rd_hit      = hit && (kind == KIND_READ);
    assign wr_ec       = hit && (kind == KIND_WRITE) && (off == OFF_EC);
    assign wr_ed       = hit && (kind == KIND_WRITE) && (off == OFF_ED);
    assign wr_ef       = hit && (kind == KIND_WRITE) && (off == OFF_EF);
    assign rd_ee       = rd_hit && (off == OFF_EE);
    assign in_scr_area = (off[DATA_W-1 -: NIB_W] == SCR_HI);
    assign wr_fb       = hit && (kind == KIND_WRITE) && (off == OFF_FB);
    assign wr_scr      = hit && (kind == KIND_WRITE) && in_scr_area && (off != OFF_FB);
    assign use_scr     = rd_hit && in_scr_area && (off != OFF_FB);
    assign refresh     = wr_ec || wr_ed || wr_ef || rd_ee;
    assign scr_idx     = SCR_AW'({slot, off[NIB_W-1:0]});

    // Pick the window byte held before the update
    always_comb
    begin
        unique case (off)
            OFF_EC:         rd_pre = ec_reg[slot];
            OFF_ED:         rd_pre = {{(DATA_W-NIB_W){1'b0}}, ed_reg[slot]};
            OFF_EE, OFF_EF: rd_pre = ee_reg[slot];
            OFF_FB:         rd_pre = fb_reg[slot];
            default:        rd_pre = '0;
        endcase
    end

    // Next pointer
    always_comb
    begin
        priority if (wr_ec)
        begin
            ptr_next = {ptr_reg[PTR_W-1:DATA_W], data};
        end
        else if (wr_ed)
        begin
            ptr_next = {data[NIB_W-1:0], ptr_reg[DATA_W-1:0]};
        end
        else if (wr_ef || rd_ee)
        begin
            ptr_next = ptr_reg + PTR_W'(1);
        end
        else
        begin
            ptr_next = ptr_reg;
        end
    end

    // Reduce the pointer modulo the buffer depth by shifted compare and subtract
    always_comb
    begin
        ptr_mod = ptr_next;
        for (int k = RED_STEPS - 1; k >= 0; k--)
        begin
            if (32'(ptr_mod) >= (BUFFER_DEPTH << k))
            begin
                ptr_mod = ptr_mod - PTR_W'(BUFFER_DEPTH << k);
            end
        end
    end

    assign buf_rd_addr = BUF_AW'(ptr_mod);

    // Buffer write port: clearing sweep or a store at the current pointer
    assign buf_wr_en   = cmd.clear || (cmd.accept && wr_ef);
    assign buf_wr_addr = cmd.clear ? clr_cnt_reg : buf_addr_reg;
    assign buf_wr_data = cmd.clear ? '0 : data;

    srcw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_buf_ram (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (buf_wr_addr),
        .wr_data (buf_wr_data),
        .rd_en   (cmd.accept),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_data)
    );

    srcw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SCR_DEPTH)
    ) u_scr_ram (
        .clk     (clk),
        .wr_en   (cmd.accept && wr_scr),
        .wr_addr (scr_idx),
        .wr_data (data),
        .rd_en   (cmd.accept),
        .rd_addr (scr_idx),
        .rd_data (scr_rd_data)
    );

    // Advance the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + BUF_AW'(1);
        end
    end

    assign status.clear_last = (clr_cnt_reg == CLR_LAST);

    // Pointer and scratch valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg         <= '0;
            buf_addr_reg    <= '0;
            scr_vld_vec_reg <= '0;
        end
        else if (cmd.accept)
        begin
            ptr_reg      <= ptr_next;
            buf_addr_reg <= buf_rd_addr;
            if (wr_scr)
            begin
                scr_vld_vec_reg[scr_idx] <= 1'b1;
            end
        end
    end

    // Refreshed data byte, forwarding a store to the same buffer entry
    assign refresh_byte = fwd_reg ? fwd_data_reg : buf_rd_data;

    // Per-slot window bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= NUM_SLOTS; s++)
            begin
                ec_reg[s] <= '0;
                ed_reg[s] <= '0;
                ee_reg[s] <= '0;
                fb_reg[s] <= '0;
            end
        end
        else
        begin
            if (cmd.accept && (wr_ec || rd_ee))
            begin
                ec_reg[slot] <= wr_ec ? data : ptr_next[DATA_W-1:0];
            end
            if (cmd.accept && (wr_ed || rd_ee))
            begin
                ed_reg[slot] <= wr_ed ? data[NIB_W-1:0] : ptr_next[PTR_W-1:DATA_W];
            end
            if (cmd.accept && wr_fb)
            begin
                fb_reg[slot] <= data;
            end
            if (cmd.finish && refresh_reg)
            begin
                ee_reg[slot_reg] <= refresh_byte;
            end
            // Card type lands in every slot
            if (cfg_wr_en)
            begin
                for (int s = 1; s <= NUM_SLOTS; s++)
                begin
                    fb_reg[s] <= cfg_wr_data;
                end
            end
        end
    end

    // Hold the item until its result is formed
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            slot_reg     <= slot;
            off4_reg     <= off[NIB_W-1:0];
            hit_reg      <= hit;
            refresh_reg  <= refresh;
            use_scr_reg  <= use_scr;
            scr_vld_reg  <= scr_vld_vec_reg[scr_idx];
            held_reg     <= rd_hit ? rd_pre : '0;
            fwd_reg      <= wr_ef && (buf_addr_reg == buf_rd_addr);
            fwd_data_reg <= data;
        end
    end

    // Result byte: scratch RAM, its reset content, or the held window byte
    always_comb
    begin
        if (use_scr_reg)
        begin
            result_byte = scr_vld_reg ? scr_rd_data : scr_init(slot_reg, off4_reg);
        end
        else
        begin
            result_byte = held_reg;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            read_data_reg  <= result_byte;
            window_hit_reg <= hit_reg;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign read_data       = read_data_reg;
    assign window_hit      = window_hit_reg;

endmodule

FILE: sv/srcw_check.sv
// Port-level checker for the slot-ROM configuration window, bound to the top level.
// Depends on srcw_pkg for field widths.
module srcw_check (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [srcw_pkg::DATA_W-1:0] read_data,
    input logic                        window_hit
);
    import srcw_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(window_hit))
        else $error("result changed while stalled");

    // A miss never carries data
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !window_hit |-> read_data == '0)
        else $error("nonzero read_data without window hit");

    // One item at a time: stall right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted while another is in flight");

    // Result reaches out_valid through the item registers and the output register when the output side drains
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (!out_valid || !out_stall) |-> ##2 out_valid)
        else $error("result missing two cycles after accept");

endmodule

bind slot_rom_config_window_top srcw_check u_srcw_check (.*);
